/* rtl/qrs_pkg.sv */
// Shared widths, the divider latency and the root class codes of the quadratic root solver.
// No dependencies; every other file imports this package.
package qrs_pkg;

  // Coefficient format and result widths.
  localparam int CW      = 24;
  localparam int FB      = 12;
  localparam int OUT_W   = 32;
  localparam int DISC_W  = 2 * CW + 2;
  // Square root of the discriminant magnitude.
  localparam int SQ_W    = DISC_W / 2;
  // Divider operands: numerator magnitude and divisor magnitude.
  localparam int MAG_W   = CW + 2;
  localparam int NUM_W   = MAG_W + FB;
  localparam int DEN_W   = CW + 1;
  localparam int DIV_LAT = NUM_W + 1;

  typedef logic signed [CW-1:0] coeff_t;

  typedef enum logic [1:0] {
    CLS_EQUAL   = 2'd0,
    CLS_REAL    = 2'd1,
    CLS_COMPLEX = 2'd2,
    CLS_AZERO   = 2'd3
  } root_class_t;

endpackage

/* rtl/qrs_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg for the radicand and root widths.
module qrs_sqrt (
  input  logic                       clk,
  input  logic [qrs_pkg::DISC_W-1:0] radicand,
  output logic [qrs_pkg::SQ_W-1:0]   root
);
  import qrs_pkg::*;

  localparam int RW = SQ_W + 2;

  logic [RW-1:0]     rem_q  [SQ_W];
  logic [SQ_W-1:0]   root_q [SQ_W];
  logic [DISC_W-1:0] rad_q  [SQ_W];

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar i = 0; i < SQ_W; i++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [SQ_W-1:0]   root_in;
    logic [DISC_W-1:0] rad_in;
    logic [RW+1:0]     shifted;
    logic [RW+1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign shifted = {rem_in, rad_in[DISC_W-1 -: 2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign ge      = (shifted >= trial);

    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? RW'(shifted - trial) : RW'(shifted);
      root_q[i] <= {root_in[SQ_W-2:0], ge};
      rad_q[i]  <= {rad_in[DISC_W-3:0], 2'b00};
    end
  end

  assign root = root_q[SQ_W-1];

endmodule

/* rtl/qrs_div.sv */
// Pipelined signed divider, truncating toward zero, with saturation to the result width.
// Restoring division, one quotient bit per stage; depends on qrs_pkg.
module qrs_div (
  input  logic                      clk,
  input  logic                      num_neg,
  input  logic [qrs_pkg::NUM_W-1:0] num_mag,
  input  logic                      den_neg,
  input  logic [qrs_pkg::DEN_W-1:0] den_mag,
  output logic [qrs_pkg::OUT_W-1:0] quot,
  output logic                      sat
);
  import qrs_pkg::*;

  logic [DEN_W-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0] part_q [NUM_W];
  logic [DEN_W-1:0] den_q  [NUM_W];
  logic             neg_q  [NUM_W];

  // Each stage shifts one numerator bit into the remainder and one quotient bit into the partial word.
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] part_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic [DEN_W:0]   shifted;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign part_in = num_mag;
      assign den_in  = den_mag;
      assign neg_in  = num_neg ^ den_neg;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign part_in = part_q[i-1];
      assign den_in  = den_q[i-1];
      assign neg_in  = neg_q[i-1];
    end

    assign shifted = {rem_in, part_in[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? DEN_W'(shifted - {1'b0, den_in}) : DEN_W'(shifted);
      part_q[i] <= {part_in[NUM_W-2:0], ge};
      den_q[i]  <= den_in;
      neg_q[i]  <= neg_in;
    end
  end

  // Apply the sign and clamp the magnitude to the signed result range.
  logic [NUM_W-1:0] mag;
  logic             high_bits;
  logic             low_bits;
  logic [OUT_W-1:0] quot_next;
  logic             sat_next;

  assign mag       = part_q[NUM_W-1];
  assign high_bits = |mag[NUM_W-1:OUT_W];
  assign low_bits  = |mag[OUT_W-2:0];

  always_comb begin
    if (neg_q[NUM_W-1]) begin
      sat_next  = high_bits || (mag[OUT_W-1] && low_bits);
      quot_next = sat_next ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-mag);
    end else begin
      sat_next  = high_bits || mag[OUT_W-1];
      quot_next = sat_next ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
    sat  <= sat_next;
  end

endmodule

/* rtl/quadratic_root_solver.sv */
// Top level of the fixed-point quadratic root solver.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------------
//  input   | coeff_a, coeff_b, coeff_c                 | start high, busy low
//  result  | root_class, first_value, second_value,    | done high for one cycle
//          | root_sum, root_product, discriminant,     |
//          | saturated                                 |
//
// One word enters per cycle; busy never rises. Each result follows its input
// word through the input, product and discriminant registers, the bit-per-stage
// square root, the operand register, the bit-per-stage dividers and the result register.
// Synchronous reset clears only the valid bits along the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quadratic_root_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::CW-1:0]     coeff_a,
  input  logic signed [qrs_pkg::CW-1:0]     coeff_b,
  input  logic signed [qrs_pkg::CW-1:0]     coeff_c,
  output logic                              done,
  output logic [1:0]                        root_class,
  output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
  output logic signed [qrs_pkg::OUT_W-1:0]  second_value,
  output logic signed [qrs_pkg::OUT_W-1:0]  root_sum,
  output logic signed [qrs_pkg::OUT_W-1:0]  root_product,
  output logic signed [qrs_pkg::DISC_W-1:0] discriminant,
  output logic                              saturated
);
  import qrs_pkg::*;

  localparam int TW = SQ_W + 2;

  typedef struct packed {
    coeff_t                    a;
    coeff_t                    b;
    coeff_t                    c;
    root_class_t               cls;
    logic signed [DISC_W-1:0]  disc;
  } sq_side_t;

  typedef struct packed {
    root_class_t               cls;
    logic signed [DISC_W-1:0]  disc;
  } div_side_t;

  function automatic logic [CW-1:0] abs_c(input coeff_t v);
    abs_c = v[CW-1] ? CW'(-v) : v;
  endfunction

  function automatic logic [MAG_W-1:0] abs_t(input logic signed [TW-1:0] v);
    abs_t = v[TW-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  assign busy = 1'b0;

  // Input register.
  logic   v1;
  coeff_t a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= coeff_a;
    b1 <= coeff_b;
    c1 <= coeff_c;
  end

  // Products b*b and a*c.
  logic                   v2;
  logic signed [2*CW-1:0] bb, ac;
  coeff_t                 a2, b2, c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    bb <= b1 * b1;
    ac <= a1 * c1;
    a2 <= a1;
    b2 <= b1;
    c2 <= c1;
  end

  // Discriminant, root class and the radicand magnitude.
  logic signed [DISC_W-1:0] disc_calc;
  root_class_t              cls_calc;
  logic                     v3;
  sq_side_t                 side3;
  logic [DISC_W-1:0]        radicand;

  assign disc_calc = {{(DISC_W-2*CW){bb[2*CW-1]}}, bb} - {ac, 2'b00};

  always_comb begin
    if (a2 == '0) begin
      cls_calc = CLS_AZERO;
    end else if (disc_calc == '0) begin
      cls_calc = CLS_EQUAL;
    end else if (!disc_calc[DISC_W-1]) begin
      cls_calc = CLS_REAL;
    end else begin
      cls_calc = CLS_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    side3    <= '{a: a2, b: b2, c: c2, cls: cls_calc, disc: disc_calc};
    radicand <= disc_calc[DISC_W-1] ? DISC_W'(-disc_calc) : disc_calc;
  end

  // Square root, with the side data delayed alongside.
  logic [SQ_W-1:0] sroot;
  logic            sq_v    [SQ_W];
  sq_side_t        sq_side [SQ_W];

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .radicand (radicand),
    .root     (sroot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQ_W; i++) begin
        sq_v[i] <= 1'b0;
      end
    end else begin
      sq_v[0] <= v3;
      for (int i = 1; i < SQ_W; i++) begin
        sq_v[i] <= sq_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_side[0] <= side3;
    for (int i = 1; i < SQ_W; i++) begin
      sq_side[i] <= sq_side[i-1];
    end
  end

  // Divider operands for the four quotients.
  sq_side_t                sp;
  logic signed [TW-1:0]    s_ext, b_ext, t_plus, t_minus;
  logic [MAG_W-1:0]        b_mag;
  logic [CW-1:0]           a_mag;

  assign sp      = sq_side[SQ_W-1];
  assign s_ext   = $signed({2'b00, sroot});
  assign b_ext   = {{(TW-CW){sp.b[CW-1]}}, sp.b};
  assign t_plus  = s_ext - b_ext;
  assign t_minus = -b_ext - s_ext;
  assign b_mag   = MAG_W'(abs_c(sp.b));
  assign a_mag   = abs_c(sp.a);

  logic             v4;
  div_side_t        side4;
  logic             sum_neg, prod_neg, v1_neg, v2_neg, a_neg;
  logic [NUM_W-1:0] sum_num, prod_num, v1_num, v2_num;
  logic [DEN_W-1:0] den1, den2;
  logic             v1_neg_next, v2_neg_next;
  logic [MAG_W-1:0] v1_mag_next, v2_mag_next;

  always_comb begin
    v1_neg_next = !sp.b[CW-1];
    v1_mag_next = b_mag;
    v2_neg_next = !sp.b[CW-1];
    v2_mag_next = b_mag;
    case (sp.cls)
      CLS_REAL: begin
        v1_neg_next = t_plus[TW-1];
        v1_mag_next = abs_t(t_plus);
        v2_neg_next = t_minus[TW-1];
        v2_mag_next = abs_t(t_minus);
      end
      CLS_COMPLEX: begin
        v2_neg_next = 1'b0;
        v2_mag_next = MAG_W'(sroot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sq_v[SQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    side4    <= '{cls: sp.cls, disc: sp.disc};
    a_neg    <= sp.a[CW-1];
    sum_neg  <= !sp.b[CW-1];
    sum_num  <= {b_mag, {FB{1'b0}}};
    prod_neg <= sp.c[CW-1];
    prod_num <= {MAG_W'(abs_c(sp.c)), {FB{1'b0}}};
    v1_neg   <= v1_neg_next;
    v1_num   <= {v1_mag_next, {FB{1'b0}}};
    v2_neg   <= v2_neg_next;
    v2_num   <= {v2_mag_next, {FB{1'b0}}};
    den1     <= DEN_W'(a_mag);
    den2     <= {a_mag, 1'b0};
  end

  // Four dividers in parallel.
  logic [OUT_W-1:0] q_sum, q_prod, q_v1, q_v2;
  logic             s_sum, s_prod, s_v1, s_v2;

  qrs_div u_div_sum (
    .clk (clk), .num_neg (sum_neg), .num_mag (sum_num),
    .den_neg (a_neg), .den_mag (den1), .quot (q_sum), .sat (s_sum)
  );

  qrs_div u_div_prod (
    .clk (clk), .num_neg (prod_neg), .num_mag (prod_num),
    .den_neg (a_neg), .den_mag (den1), .quot (q_prod), .sat (s_prod)
  );

  qrs_div u_div_v1 (
    .clk (clk), .num_neg (v1_neg), .num_mag (v1_num),
    .den_neg (a_neg), .den_mag (den2), .quot (q_v1), .sat (s_v1)
  );

  qrs_div u_div_v2 (
    .clk (clk), .num_neg (v2_neg), .num_mag (v2_num),
    .den_neg (a_neg), .den_mag (den2), .quot (q_v2), .sat (s_v2)
  );

  logic      dv    [DIV_LAT];
  div_side_t dside [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dv[i] <= 1'b0;
      end
    end else begin
      dv[0] <= v4;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dside[0] <= side4;
    for (int i = 1; i < DIV_LAT; i++) begin
      dside[i] <= dside[i-1];
    end
  end

  // Result register; a zero leading coefficient forces the quotients to zero.
  div_side_t dp;
  logic      a_zero;

  assign dp     = dside[DIV_LAT-1];
  assign a_zero = (dp.cls == CLS_AZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    root_class   <= dp.cls;
    discriminant <= dp.disc;
    first_value  <= a_zero ? '0 : q_v1;
    second_value <= a_zero ? '0 : q_v2;
    root_sum     <= a_zero ? '0 : q_sum;
    root_product <= a_zero ? '0 : q_prod;
    saturated    <= !a_zero && (s_sum || s_prod || s_v1 || s_v2);
  end

  // Checks on the result word.
  assert property (@(posedge clk) disable iff (rst)
    done && root_class == CLS_AZERO |-> first_value == '0 && second_value == '0
      && root_sum == '0 && root_product == '0 && !saturated)
    else $error("zero leading coefficient gave nonzero results");

  assert property (@(posedge clk) disable iff (rst)
    done && root_class == CLS_EQUAL |-> first_value == second_value
      && discriminant == '0)
    else $error("equal roots differ");

  assert property (@(posedge clk) disable iff (rst)
    done && root_class == CLS_COMPLEX |-> discriminant[DISC_W-1])
    else $error("complex class with nonnegative discriminant");

  assert property (@(posedge clk) disable iff (rst)
    done && root_class == CLS_REAL |-> !discriminant[DISC_W-1] && discriminant != '0)
    else $error("real class with nonpositive discriminant");

endmodule
